FILE: rtl/core/lsd_pkg.sv
// lsd_pkg: shared types and constants of the lsb stego stream decoder
`timescale 1ns / 1ps
package lsd_pkg;

	// decode phases
	typedef enum logic [2:0] {
		PH_SKIP,
		PH_MAGIC,
		PH_EXTLEN,
		PH_EXT,
		PH_DATALEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_EXT  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_NL   = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
	localparam logic [1:0] CFG_MAGIC_VALUE  = 2'd1;
	localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd2;

	localparam logic [15:0] LSD_SKIP_RESET      = 16'd54;
	localparam logic [63:0] LSD_MAGIC_RESET     = 64'd0;
	localparam logic [3:0]  LSD_MAGIC_LEN_RESET = 4'd2;
	localparam logic [3:0]  LSD_MAGIC_LEN_MAX   = 4'd8;
	localparam logic [7:0]  LSD_NEWLINE         = 8'h0A;

	// bit count at which a field completes (a 32-bit field wraps the 5-bit counter)
	localparam logic [4:0] FIELD_BYTE = 5'd8;
	localparam logic [4:0] FIELD_WORD = 5'd0;

	localparam int unsigned LSD_RESULT_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} result_t;

	// results produced by one decode step, second only together with the first
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

FILE: rtl/core/lsd_if.sv
// lsd_if: valid/ready channels for carrier bytes and decoded results
`timescale 1ns / 1ps
interface lsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] carrier_byte;

	modport source(output valid, output carrier_byte, input ready);
	modport sink(input valid, input carrier_byte, output ready);
endinterface

interface lsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       last;

	modport source(output valid, output out_byte, output out_kind, output last, input ready);
	modport sink(input valid, input out_byte, input out_kind, input last, output ready);
endinterface

FILE: rtl/core/lsb_stego_stream_decoder.sv
// lsb_stego_stream_decoder: recovers hidden fields from the carrier byte lsbs
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------
//   carrier  | in  | valid / ready | carrier_byte[7:0]
//   result   | out | valid / ready | out_byte[7:0] out_kind[1:0] last
//   cfg      | in  | cfg_we        | cfg_index[1:0] cfg_data[63:0]
//
// one carrier byte per cycle: the lsb is held in an input register and the
// decode step then updates counters and the shift register from it.
// results go into a small queue that feeds the result channel; the step
// waits only while the queue has fewer than two free entries.
// reset returns to header skip with default registers; no clearing pass.
`timescale 1ns / 1ps
module lsb_stego_stream_decoder #(
	parameter int unsigned RESULT_DEPTH = lsd_pkg::LSD_RESULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	lsd_in_if.sink      carrier,
	lsd_out_if.source   result
);
	import lsd_pkg::*;

	// configuration
	logic [15:0] header_skip_q;
	logic [63:0] magic_value_q;
	logic [3:0]  magic_length_q;

	// decode state
	phase_t      phase_q, phase_d;
	logic [15:0] skip_cnt_q, skip_cnt_d;
	logic [4:0]  bit_cnt_q, bit_cnt_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] item_cnt_q, item_cnt_d;
	logic        magic_ok_q, magic_ok_d;
	logic [31:0] ext_len_q, ext_len_d;
	logic [31:0] pay_cnt_q, pay_cnt_d;

	// input register
	logic        bit_s1;
	logic        valid_s1;

	logic        room, step, skipping, field_done, magic_blocked, magic_end;
	logic        ext_end, data_end, magic_ok_nx;
	phase_t      eff_phase;
	logic [31:0] shift_nx, item_inc, pay_cnt_nx;
	logic [4:0]  cnt_inc, need;
	logic [3:0]  len_eff, expect_idx;
	logic [7:0]  expect_byte;
	push_t       push;
	result_t     head;
	logic        head_valid;

	assign step            = valid_s1 && room;
	assign carrier.ready   = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (carrier.ready) begin
			valid_s1 <= carrier.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (carrier.ready && carrier.valid) begin
			bit_s1 <= carrier.carrier_byte[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_skip_q  <= LSD_SKIP_RESET;
			magic_value_q  <= LSD_MAGIC_RESET;
			magic_length_q <= LSD_MAGIC_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_SKIP:  header_skip_q  <= cfg_data[15:0];
				CFG_MAGIC_VALUE:  magic_value_q  <= cfg_data;
				CFG_MAGIC_LENGTH: magic_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// shared step terms
	assign skipping  = (phase_q == PH_SKIP) && (skip_cnt_q < header_skip_q);
	assign eff_phase = (phase_q == PH_SKIP) ? PH_MAGIC : phase_q;
	assign shift_nx  = {shift_q[30:0], bit_s1};
	assign cnt_inc   = bit_cnt_q + 5'd1;
	assign item_inc  = item_cnt_q + 32'd1;

	always_comb begin
		case (eff_phase)
			PH_MAGIC, PH_EXT, PH_DATA: need = FIELD_BYTE;
			default:                   need = FIELD_WORD;
		endcase
	end
	assign field_done = (cnt_inc == need);

	// out-of-range signature length is clamped to 1..8
	assign len_eff = (magic_length_q == 4'd0) ? 4'd1 :
		(magic_length_q > LSD_MAGIC_LEN_MAX) ? LSD_MAGIC_LEN_MAX : magic_length_q;
	assign magic_blocked = (item_cnt_q >= {28'd0, len_eff});
	assign expect_idx    = len_eff - 4'd1 - item_cnt_q[3:0];
	assign expect_byte   = magic_value_q[{expect_idx[2:0], 3'b000} +: 8];
	assign magic_ok_nx   = magic_ok_q && !(field_done && (shift_nx[7:0] != expect_byte));
	assign magic_end     = !magic_blocked && field_done && (item_inc >= {28'd0, len_eff});

	assign pay_cnt_nx = (shift_nx == 32'd0) ? 32'd0 : shift_nx - 32'd1;
	assign ext_end    = item_inc >= ext_len_q;
	assign data_end   = item_inc >= pay_cnt_q;

	// next state
	always_comb begin
		phase_d    = phase_q;
		skip_cnt_d = skip_cnt_q;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		item_cnt_d = item_cnt_q;
		magic_ok_d = magic_ok_q;
		ext_len_d  = ext_len_q;
		pay_cnt_d  = pay_cnt_q;
		if (step) begin
			if (skipping) begin
				skip_cnt_d = skip_cnt_q + 16'd1;
			end else begin
				phase_d = eff_phase;
				unique case (eff_phase)
					PH_MAGIC: begin
						if (!magic_blocked) begin
							bit_cnt_d = field_done ? 5'd0 : cnt_inc;
							shift_d   = field_done ? 32'd0 : shift_nx;
							if (field_done) begin
								item_cnt_d = item_inc;
								magic_ok_d = magic_ok_nx;
							end
							if (magic_end) begin
								item_cnt_d = '0;
								phase_d    = magic_ok_nx ? PH_EXTLEN : PH_DONE;
							end
						end
					end
					PH_EXTLEN: begin
						bit_cnt_d = field_done ? 5'd0 : cnt_inc;
						shift_d   = field_done ? 32'd0 : shift_nx;
						if (field_done) begin
							ext_len_d  = shift_nx;
							item_cnt_d = '0;
							phase_d    = (shift_nx == 32'd0) ? PH_DATALEN : PH_EXT;
						end
					end
					PH_EXT: begin
						bit_cnt_d = field_done ? 5'd0 : cnt_inc;
						shift_d   = field_done ? 32'd0 : shift_nx;
						if (field_done) begin
							item_cnt_d = ext_end ? 32'd0 : item_inc;
							if (ext_end) begin
								phase_d = PH_DATALEN;
							end
						end
					end
					PH_DATALEN: begin
						bit_cnt_d = field_done ? 5'd0 : cnt_inc;
						shift_d   = field_done ? 32'd0 : shift_nx;
						if (field_done) begin
							pay_cnt_d  = pay_cnt_nx;
							item_cnt_d = '0;
							phase_d    = (pay_cnt_nx == 32'd0) ? PH_DONE : PH_DATA;
						end
					end
					PH_DATA: begin
						bit_cnt_d = field_done ? 5'd0 : cnt_inc;
						shift_d   = field_done ? 32'd0 : shift_nx;
						if (field_done) begin
							item_cnt_d = item_inc;
							if (data_end) begin
								phase_d = PH_DONE;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// results of this step
	always_comb begin
		push    = '0;
		push.r0 = '{data: shift_nx[7:0], kind: KIND_EXT, last: 1'b0};
		push.r1 = '{data: LSD_NEWLINE, kind: KIND_NL, last: 1'b1};
		if (step && !skipping) begin
			unique case (eff_phase)
				PH_MAGIC: begin
					if (magic_end && !magic_ok_nx) begin
						push.v0 = 1'b1;
						push.r0 = '{data: 8'd0, kind: KIND_BAD, last: 1'b1};
					end
				end
				PH_EXT: begin
					push.v0 = field_done;
				end
				PH_DATALEN: begin
					if (field_done && (pay_cnt_nx == 32'd0)) begin
						push.v0 = 1'b1;
						push.r0 = '{data: LSD_NEWLINE, kind: KIND_NL, last: 1'b1};
					end
				end
				PH_DATA: begin
					push.v0      = field_done;
					push.r0.kind = KIND_DATA;
					push.v1      = field_done && data_end;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			skip_cnt_q <= '0;
			bit_cnt_q  <= '0;
			shift_q    <= '0;
			item_cnt_q <= '0;
			magic_ok_q <= 1'b1;
			ext_len_q  <= '0;
			pay_cnt_q  <= '0;
		end else begin
			phase_q    <= phase_d;
			skip_cnt_q <= skip_cnt_d;
			bit_cnt_q  <= bit_cnt_d;
			shift_q    <= shift_d;
			item_cnt_q <= item_cnt_d;
			magic_ok_q <= magic_ok_d;
			ext_len_q  <= ext_len_d;
			pay_cnt_q  <= pay_cnt_d;
		end
	end

	lsd_result_fifo #(
		.DEPTH(RESULT_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (result.ready),
		.head       (head),
		.head_valid (head_valid),
		.room       (room)
	);

	assign result.valid    = head_valid;
	assign result.out_byte = head.data;
	assign result.out_kind = head.kind;
	assign result.last     = head.last;

endmodule

FILE: rtl/core/lsd_result_fifo.sv
// lsd_result_fifo: small result queue taking up to two results per cycle
`timescale 1ns / 1ps
module lsd_result_fifo #(
	parameter int unsigned DEPTH = lsd_pkg::LSD_RESULT_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lsd_pkg::push_t   push,
	input  logic             pop,
	output lsd_pkg::result_t head,
	output logic             head_valid,
	output logic             room
);
	import lsd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_next1, wr_next2;
	logic            do_pop;
	logic [CW-1:0]   n_push;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	assign wr_next1   = ptr_inc(wr_ptr_q);
	assign wr_next2   = ptr_inc(wr_next1);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;
	assign room       = (count_q <= ROOM_MAX);
	assign n_push     = CW'(push.v0) + CW'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_next1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.v1) begin
				wr_ptr_q <= wr_next2;
			end else if (push.v0) begin
				wr_ptr_q <= wr_next1;
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + n_push - CW'(do_pop);
		end
	end

endmodule
